>>> design/priority_aging_quantum_dispatcher_top_macros.svh
// Assertion macros for the dispatcher top level.
// Depends on nothing; users supply aclk and aresetn in scope.
`ifndef PRIORITY_AGING_QUANTUM_DISPATCHER_TOP_MACROS_SVH
`define PRIORITY_AGING_QUANTUM_DISPATCHER_TOP_MACROS_SVH

// same-cycle implication
`define PAQD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PAQD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/paqd_pkg.sv
// Shared types and constants of the priority dispatcher.
// No dependencies.
`default_nettype none

package paqd_pkg;

    localparam logic [15:0] QUANTUM_RESET = 16'd100;
    localparam logic [7:0]  PRI_MAX       = 8'd255;

    localparam logic [1:0] STAT_LOADED     = 2'd0;
    localparam logic [1:0] STAT_DISPATCHED = 2'd1;
    localparam logic [1:0] STAT_FULL       = 2'd2;
    localparam logic [1:0] STAT_EMPTY      = 2'd3;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    // one table entry
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] arrival;
        logic [7:0]  priority_val;
        logic [23:0] remaining;
    } slot_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DSP_RD,
        S_DSP_CALC,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_INS_RD,
        S_INS_CMP,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

>>> design/paqd_slot_ram.sv
// Ready-table storage: circular buffer addressed by logical index from head.
// Depends on paqd_pkg (slot_t).
`default_nettype none

module paqd_slot_ram
    import paqd_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                       aclk,
    input  wire logic [$clog2(DEPTH)-1:0]   head,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_idx,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_idx,
    input  wire slot_t                      wr_data,
    output slot_t                           rd_data
);

    localparam int AW = $clog2(DEPTH);

    slot_t mem [DEPTH];

    // logical -> physical, sum stays below twice the depth
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, h} + {1'b0, idx};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[phys(head, wr_idx)] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[phys(head, rd_idx)];
        end
    end

endmodule

`default_nettype wire

>>> design/priority_aging_quantum_dispatcher_top.sv
// Priority dispatcher with aging and time quantum: sequencer and datapath.
// Depends on paqd_pkg, paqd_slot_ram and the assertion macro header.
//
// Usage:
//  - Input channel s_*: one word per command. opcode 0 loads a job (id,
//    arrival, priority, burst); opcode 1 dispatches the head job.
//  - Output channel m_*: exactly one word per command with run id,
//    priority before aging, cycles granted and status.
//  - cfg_we/cfg_wdata write time_quantum; write only while idle.
//  - The table is a circular buffer in one RAM (one read, one write per
//    cycle). Dispatch pops by moving the head pointer. A load scans from
//    the head for its place, then shifts from the tail down to it, one
//    entry per cycle; a reinsert walks from the tail only.
//  - A load takes longer the more entries it scans and shifts (least into
//    an empty table); a dispatch whose job finishes is shortest, else it
//    grows with the entries behind the aged job. The scan and the shift
//    loop set the worst case. Zero-burst, full-table and empty-table
//    commands go straight to the response.
//  - s_ready is high only while the sequencer idles; a finished word may
//    still sit in the output register when the next command is accepted.
//    If the receiver stalls, the next result waits until the register
//    frees, and the block takes no new command meanwhile.
//  - Reset (aresetn low, synchronous) empties the table, restores the
//    quantum to 100 and drops any pending output word. No clearing pass.
`default_nettype none

`include "priority_aging_quantum_dispatcher_top_macros.svh"

module priority_aging_quantum_dispatcher_top
    import paqd_pkg::*;
#(
    parameter int MAX_JOBS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_opcode,
    input  wire logic [15:0] s_job_id,
    input  wire logic [31:0] s_arrival_time,
    input  wire logic [7:0]  s_job_priority,
    input  wire logic [23:0] s_burst_cycles,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_run_id,
    output logic [7:0]       m_run_priority,
    output logic [15:0]      m_cycles_run,
    output logic [1:0]       m_status
);

    localparam int AW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;       // entries in the table
    logic [AW-1:0] head_reg, head_next;     // physical slot of logical 0
    logic [CW-1:0] k_reg, k_next;           // insert cursor (logical)
    logic [CW-1:0] pos_reg, pos_next;       // place of a load (logical)
    slot_t         new_reg, new_next;       // entry being inserted
    logic          age_reg, age_next;       // 1: reinsert after aging
    logic [15:0]   quantum_reg;

    logic [15:0]   res_id_reg, res_id_next;
    logic [7:0]    res_pri_reg, res_pri_next;
    logic [15:0]   res_cyc_reg, res_cyc_next;
    logic [1:0]    res_stat_reg, res_stat_next;

    logic          m_valid_reg;
    logic [15:0]   m_id_reg;
    logic [7:0]    m_pri_reg;
    logic [15:0]   m_cyc_reg;
    logic [1:0]    m_stat_reg;

    // RAM side
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_idx, wr_idx;
    slot_t         wr_data, rd_data;

    logic s_acc, out_free, is_full, move, later, k_last, pos_last;
    logic [15:0] run_cycles;
    logic [7:0]  aged_pri;
    logic [23:0] left_cycles;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_full  = (cnt_reg == CW'(MAX_JOBS));
    assign k_last   = (k_reg == CW'(1));
    assign pos_last = ((pos_reg + CW'(1)) == cnt_reg);

    // shared order compare
    // later: stored entry belongs behind the new load (head scan).
    // move: stored entry shifts up one slot (tail walk). Priority values are
    // sorted, so a reinsert stops at the first smaller-or-equal value; arrivals
    // inside one priority need not be sorted, so a load uses its scanned place.
    always_comb begin
        later = (rd_data.priority_val > new_reg.priority_val) ||
                ((rd_data.priority_val == new_reg.priority_val) &&
                 (rd_data.arrival > new_reg.arrival));
        if (age_reg) begin
            move = rd_data.priority_val > new_reg.priority_val;
        end else begin
            move = (k_reg > pos_reg);
        end
    end

    // slice arithmetic on the head entry
    always_comb begin
        if (rd_data.remaining < {8'd0, quantum_reg}) begin
            run_cycles = rd_data.remaining[15:0];
        end else begin
            run_cycles = quantum_reg;
        end
        aged_pri    = (rd_data.priority_val == PRI_MAX) ? PRI_MAX
                                                        : rd_data.priority_val + 8'd1;
        left_cycles = rd_data.remaining - {8'd0, run_cycles};
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (s_opcode == OP_LOAD) begin
                        if (s_burst_cycles == 24'd0 || is_full) begin
                            state_next = S_RESP;
                        end else begin
                            state_next = S_SRCH_RD;
                        end
                    end else begin
                        state_next = (cnt_reg == '0) ? S_RESP : S_DSP_RD;
                    end
                end
            end
            S_DSP_RD: begin
                state_next = S_DSP_CALC;
            end
            S_DSP_CALC: begin
                state_next = (left_cycles != 24'd0) ? S_INS_RD : S_RESP;
            end
            S_SRCH_RD: begin
                state_next = (pos_reg == cnt_reg) ? S_INS_RD : S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (later || pos_last) begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD: begin
                state_next = (k_reg == '0) ? S_RESP : S_INS_CMP;
            end
            S_INS_CMP: begin
                if (!move) begin
                    state_next = S_RESP;
                end else if (k_last) begin
                    state_next = S_INS_RD;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // RAM controls
    // ------------------------------------------------------------------
    always_comb begin
        rd_en   = 1'b0;
        rd_idx  = '0;
        wr_en   = 1'b0;
        wr_idx  = k_reg[AW-1:0];
        wr_data = new_reg;
        case (state_reg)
            S_DSP_RD: begin
                rd_en = 1'b1;
            end
            S_SRCH_RD: begin
                if (pos_reg != cnt_reg) begin
                    rd_en  = 1'b1;
                    rd_idx = AW'(pos_reg);
                end
            end
            S_SRCH_CMP: begin
                // fetch the next entry ahead of its compare
                if (!later && !pos_last) begin
                    rd_en  = 1'b1;
                    rd_idx = AW'(pos_reg + CW'(1));
                end
            end
            S_INS_RD: begin
                if (k_reg == '0) begin
                    wr_en = 1'b1;
                end else begin
                    rd_en  = 1'b1;
                    rd_idx = AW'(k_reg - CW'(1));
                end
            end
            S_INS_CMP: begin
                wr_en = 1'b1;
                if (move) begin
                    wr_data = rd_data;
                    if (!k_last) begin
                        rd_en  = 1'b1;
                        rd_idx = AW'(k_reg - CW'(2));
                    end
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        cnt_next      = cnt_reg;
        head_next     = head_reg;
        k_next        = k_reg;
        pos_next      = pos_reg;
        new_next      = new_reg;
        age_next      = age_reg;
        res_id_next   = res_id_reg;
        res_pri_next  = res_pri_reg;
        res_cyc_next  = res_cyc_reg;
        res_stat_next = res_stat_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    res_id_next  = '0;
                    res_pri_next = '0;
                    res_cyc_next = '0;
                    new_next     = '{id: s_job_id, arrival: s_arrival_time,
                                     priority_val: s_job_priority,
                                     remaining: s_burst_cycles};
                    age_next     = 1'b0;
                    k_next       = cnt_reg;
                    pos_next     = '0;
                    if (s_opcode == OP_LOAD) begin
                        res_stat_next = (is_full && s_burst_cycles != 24'd0) ? STAT_FULL
                                                                             : STAT_LOADED;
                    end else begin
                        res_stat_next = (cnt_reg == '0) ? STAT_EMPTY : STAT_DISPATCHED;
                    end
                end
            end
            S_DSP_CALC: begin
                res_id_next  = rd_data.id;
                res_pri_next = rd_data.priority_val;
                res_cyc_next = run_cycles;
                head_next    = (head_reg == AW'(MAX_JOBS - 1)) ? '0 : head_reg + AW'(1);
                cnt_next     = cnt_reg - CW'(1);
                k_next       = cnt_reg - CW'(1);
                age_next     = 1'b1;
                new_next     = '{id: rd_data.id, arrival: rd_data.arrival,
                                 priority_val: aged_pri, remaining: left_cycles};
            end
            S_SRCH_CMP: begin
                if (!later) begin
                    pos_next = pos_reg + CW'(1);
                end
            end
            S_INS_RD: begin
                if (k_reg == '0) begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_INS_CMP: begin
                if (move) begin
                    k_next = k_reg - CW'(1);
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            head_reg    <= '0;
            quantum_reg <= QUANTUM_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            head_reg  <= head_next;
            if (cfg_we) begin
                quantum_reg <= cfg_wdata;
            end
            if (state_reg == S_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        pos_reg      <= pos_next;
        new_reg      <= new_next;
        age_reg      <= age_next;
        res_id_reg   <= res_id_next;
        res_pri_reg  <= res_pri_next;
        res_cyc_reg  <= res_cyc_next;
        res_stat_reg <= res_stat_next;
        if (state_reg == S_RESP && out_free) begin
            m_id_reg   <= res_id_reg;
            m_pri_reg  <= res_pri_reg;
            m_cyc_reg  <= res_cyc_reg;
            m_stat_reg <= res_stat_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_run_id       = m_id_reg;
    assign m_run_priority = m_pri_reg;
    assign m_cycles_run   = m_cyc_reg;
    assign m_status       = m_stat_reg;

    paqd_slot_ram #(
        .DEPTH (MAX_JOBS)
    ) u_table (
        .aclk    (aclk),
        .head    (head_reg),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `PAQD_ASSERT_NOW(a_cursor_in_table,
        (state_reg == S_INS_RD || state_reg == S_INS_CMP), (k_reg <= cnt_reg),
        "insert cursor beyond table")
    `PAQD_ASSERT_NEXT(a_count_idle_stable,
        (state_reg == S_IDLE && !s_acc), $stable(cnt_reg),
        "table count moved while idle")
    `PAQD_ASSERT_NEXT(a_full_flagged,
        (s_acc && s_opcode == OP_LOAD && is_full && s_burst_cycles != 24'd0),
        (res_stat_reg == STAT_FULL && state_reg == S_RESP),
        "load into full table not flagged")
    `PAQD_ASSERT_NEXT(a_empty_flagged,
        (s_acc && s_opcode == OP_DISPATCH && cnt_reg == '0),
        (res_stat_reg == STAT_EMPTY && cnt_reg == '0),
        "dispatch on empty table not flagged")

endmodule

`default_nettype wire

>>> sim/priority_aging_quantum_dispatcher_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the priority aging dispatcher: a ready-table model predicts each
// result word while both channels stall at random. Depends on paqd_pkg and the RTL only.

module priority_aging_quantum_dispatcher_top_test
    import paqd_pkg::*;
();

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 7;
    localparam int TABLE_DEPTH   = 64;
    // well above the worst single command, which leaves plenty of margin
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_WORDS   = 200;
    localparam int IDLE_PCT      = 9;
    localparam int MAX_REPORTS   = 10;

    // one command word on the s_ channel
    typedef struct packed {
        logic        opcode;
        logic [15:0] job_id;
        logic [31:0] arrival;
        logic [7:0]  prio;
        logic [23:0] burst;
    } job_cmd_t;

    // one result word on the m_ channel
    typedef struct packed {
        logic [15:0] run_id;
        logic [7:0]  run_prio;
        logic [15:0] cycles;
        logic [1:0]  status;
    } run_word_t;

    // Ready table kept in priority order, plus the words it is owed.
    class ready_table_model;
        slot_t       ready_jobs[$];
        run_word_t   expected_words[$];
        logic [15:0] quantum;
        int          mismatches;

        function new();
            quantum    = QUANTUM_RESET;
            mismatches = 0;
        endfunction

        function void set_quantum(logic [15:0] q);
            quantum = q;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void note_command(job_cmd_t c);
            run_word_t   w;
            slot_t       job;
            int          pos;
            logic [23:0] slice;
            w        = '0;
            w.status = STAT_LOADED;
            if (c.opcode == OP_LOAD) begin
                // a zero-length job is acknowledged but never stored
                if (c.burst != 0) begin
                    if (ready_jobs.size() >= TABLE_DEPTH) begin
                        w.status = STAT_FULL;
                    end else begin
                        pos = 0;
                        while (pos < ready_jobs.size() &&
                               (ready_jobs[pos].priority_val < c.prio ||
                                (ready_jobs[pos].priority_val == c.prio &&
                                 ready_jobs[pos].arrival <= c.arrival)))
                            pos++;
                        job.id           = c.job_id;
                        job.arrival      = c.arrival;
                        job.priority_val = c.prio;
                        job.remaining    = c.burst;
                        ready_jobs.insert(pos, job);
                    end
                end
            end else if (ready_jobs.size() == 0) begin
                w.status = STAT_EMPTY;
            end else begin
                job   = ready_jobs.pop_front();
                slice = (job.remaining < {8'd0, quantum}) ? job.remaining : {8'd0, quantum};
                w.run_id   = job.id;
                w.run_prio = job.priority_val;
                w.cycles   = slice[15:0];
                w.status   = STAT_DISPATCHED;
                // aging saturates at the top value
                if (job.priority_val != PRI_MAX)
                    job.priority_val = job.priority_val + 8'd1;
                job.remaining = job.remaining - slice;
                if (job.remaining != 0) begin
                    pos = 0;
                    while (pos < ready_jobs.size() &&
                           ready_jobs[pos].priority_val <= job.priority_val)
                        pos++;
                    ready_jobs.insert(pos, job);
                end
            end
            expected_words.push_back(w);
        endfunction

        function void check_word(run_word_t got);
            run_word_t want;
            bit        bad;
            want = '0;
            if (expected_words.size() == 0) begin
                bad = 1'b1;
            end else begin
                want = expected_words.pop_front();
                bad  = (want.run_id != got.run_id) || (want.run_prio != got.run_prio) ||
                       (want.cycles != got.cycles) || (want.status != got.status);
            end
            if (bad) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch %0d at %0t (%0d queued): want id=%h pri=%h cyc=%h st=%0d",
                             mismatches, $time, expected_words.size() + (want != '0),
                             want.run_id, want.run_prio, want.cycles, want.status);
                    $display("    got id=%h pri=%h cyc=%h st=%0d",
                             got.run_id, got.run_prio, got.cycles, got.status);
                end
            end
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // Clock, reset and block inputs; every input is known from time zero.
    // ---------------------------------------------------------------------
    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_we         = 1'b0;
    logic [15:0] cfg_wdata      = '0;
    logic        s_valid        = 1'b0;
    logic        s_opcode       = OP_LOAD;
    logic [15:0] s_job_id       = '0;
    logic [31:0] s_arrival_time = '0;
    logic [7:0]  s_job_priority = '0;
    logic [23:0] s_burst_cycles = '0;
    logic        m_ready        = 1'b0;

    logic        s_ready;
    logic        m_valid;
    logic [15:0] m_run_id;
    logic [7:0]  m_run_priority;
    logic [15:0] m_cycles_run;
    logic [1:0]  m_status;

    // when clear, neither side inserts bubbles (one long back-to-back stretch)
    bit idle_on = 1'b1;
    int stall_cycles = 0;

    ready_table_model table_model = new();

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    priority_aging_quantum_dispatcher_top #(
        .MAX_JOBS(TABLE_DEPTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_job_id      (s_job_id),
        .s_arrival_time(s_arrival_time),
        .s_job_priority(s_job_priority),
        .s_burst_cycles(s_burst_cycles),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_run_id      (m_run_id),
        .m_run_priority(m_run_priority),
        .m_cycles_run  (m_cycles_run),
        .m_status      (m_status)
    );

    // ---------------------------------------------------------------------
    // Result side: random back-pressure, check each accepted word, and a
    // watchdog that trips when neither channel moves a word for too long.
    // Outputs are read right after the edge, i.e. their pre-edge values.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        run_word_t seen;
        m_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        if (aresetn && m_valid && m_ready) begin
            seen.run_id   = m_run_id;
            seen.run_prio = m_run_priority;
            seen.cycles   = m_cycles_run;
            seen.status   = m_status;
            table_model.check_word(seen);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Command side
    // ---------------------------------------------------------------------
    function automatic job_cmd_t make_cmd(logic op, logic [15:0] id, logic [31:0] arr,
                                          logic [7:0] prio, logic [23:0] burst);
        job_cmd_t c;
        c.opcode  = op;
        c.job_id  = id;
        c.arrival = arr;
        c.prio    = prio;
        c.burst   = burst;
        return c;
    endfunction

    // Random command; ties and priority saturation are made common on purpose.
    function automatic job_cmd_t random_command(int load_pct);
        job_cmd_t c;
        int       pick;
        c.opcode  = ($urandom_range(99) < load_pct) ? OP_LOAD : OP_DISPATCH;
        c.job_id  = 16'($urandom);
        c.arrival = $urandom_range(1) ? $urandom : $urandom_range(15);
        pick = $urandom_range(99);
        if (pick < 40)
            c.prio = 8'($urandom_range(3));
        else if (pick < 60)
            c.prio = 8'($urandom_range(255, 252));
        else
            c.prio = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 10)
            c.burst = '0;
        else if (pick < 30)
            c.burst = 24'($urandom_range(8, 1));
        else if (pick < 75)
            c.burst = 24'($urandom_range(300, 1));
        else
            c.burst = 24'($urandom);
        return c;
    endfunction

    // Present one word, with optional bubbles first, and hold it until taken.
    task automatic send_word(input job_cmd_t c);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= c.opcode;
        s_job_id       <= c.job_id;
        s_arrival_time <= c.arrival;
        s_job_priority <= c.prio;
        s_burst_cycles <= c.burst;
        do @(posedge aclk); while (!s_ready);
        table_model.note_command(c);
    endtask

    // Every command returns a word, so an empty queue means the block is idle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (table_model.pending() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_quantum(input logic [15:0] q);
        cfg_we    <= 1'b1;
        cfg_wdata <= q;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        table_model.set_quantum(q);
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin : main_seq
        job_cmd_t    directed[$];
        logic [15:0] q;
        int          load_pct;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, at the reset quantum of 100.
        directed.push_back(make_cmd(OP_DISPATCH, 16'h0000, 32'h0, 8'h00, 24'h0)); // empty
        directed.push_back(make_cmd(OP_LOAD, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 24'h0)); // 0 cycles
        directed.push_back(make_cmd(OP_DISPATCH, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 24'hFFFFFF));
        directed.push_back(make_cmd(OP_LOAD, 16'h0000, 32'hFFFFFFFF, 8'hFF, 24'hFFFFFF));
        directed.push_back(make_cmd(OP_LOAD, 16'hFFFF, 32'h0, 8'h00, 24'd1));
        directed.push_back(make_cmd(OP_LOAD, 16'h0001, 32'd100, 8'd7, 24'd250));
        // same priority and arrival: goes behind the earlier load
        directed.push_back(make_cmd(OP_LOAD, 16'h0002, 32'd100, 8'd7, 24'd30));
        // same priority, earlier arrival: goes in front
        directed.push_back(make_cmd(OP_LOAD, 16'h0003, 32'd50, 8'd7, 24'd100));
        // runs every job but job 0 to its end; job 1 is aged and reinserted twice,
        // job 0 ends up aging at the top value and stays in the table
        repeat (8) directed.push_back(make_cmd(OP_DISPATCH, 16'h0, 32'h0, 8'h0, 24'h0));
        foreach (directed[i])
            send_word(directed[i]);

        // Zero quantum: nothing runs, jobs still age and rotate.
        wait_drained();
        write_quantum(16'd0);
        directed.delete();
        directed.push_back(make_cmd(OP_DISPATCH, 16'h0, 32'h0, 8'h0, 24'h0));
        directed.push_back(make_cmd(OP_LOAD, 16'h0009, 32'd7, 8'd254, 24'd3));
        repeat (4) directed.push_back(make_cmd(OP_DISPATCH, 16'h0, 32'h0, 8'h0, 24'h0));
        foreach (directed[i])
            send_word(directed[i]);

        // Random phases, each with a quantum set at its start. Load-heavy phases push the
        // table into the full case, light ones run it down.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: begin q = 16'hFFFF;                      load_pct = 75; end
                1: begin q = 16'd1;                         load_pct = 45; end
                2: begin q = 16'($urandom_range(400, 2));   load_pct = 25; end
                3: begin q = 16'($urandom);                 load_pct = 75; end
                4: begin q = 16'd0;                         load_pct = 60; end
                5: begin q = 16'hFFFF;                      load_pct = 20; end
                6: begin q = 16'($urandom_range(64, 1));    load_pct = 55; end
                default: begin q = QUANTUM_RESET;           load_pct = 50; end
            endcase
            write_quantum(q);
            idle_on = (ph != 3);
            repeat (PHASE_WORDS)
                send_word(random_command(load_pct));
        end

        // Let the last words come out, then allow for a stray extra word.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (table_model.mismatches == 0 && table_model.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/paqd_pkg.sv
design/paqd_slot_ram.sv
design/priority_aging_quantum_dispatcher_top.sv
sim/priority_aging_quantum_dispatcher_top_test.sv
